// ===== src/ipsvm_pkg.sv =====
// Shared types, widths and constants of the inverse Park / space vector PWM pipeline.
// No dependencies; every design module of the block imports this package, the checker does not.
package ipsvm_pkg;

  localparam int unsigned ANG_W = 16;   // turn fraction
  localparam int unsigned VOLT_W = 16;  // Q1.15 voltage command
  localparam int unsigned TRIG_W = 17;  // signed Q15 sine/cosine, peak 32768
  localparam int unsigned PROD_W = 33;  // voltage x trig product
  localparam int unsigned AB_W = 34;    // alpha/beta in Q30
  localparam int unsigned M_W = 52;     // projections in Q46
  localparam int unsigned T_W = 54;     // twice duty in Q46
  localparam int unsigned Q_W = 32;     // clamped twice duty >> 16

  localparam logic signed [17:0] SQ3_2_Q16 = 18'sd56756;
  localparam logic signed [T_W-1:0] ONE_Q46 = T_W'(64'sd1 <<< 46);
  localparam logic signed [T_W-1:0] TWO_Q46 = T_W'(64'sd1 <<< 47);
  localparam logic [ANG_W-1:0] QUARTER_TURN = 16'd16384;

  // sector codes
  localparam logic [2:0] SECTOR_ZERO = 3'd0;
  localparam logic [2:0] SECTOR_1 = 3'd1;
  localparam logic [2:0] SECTOR_2 = 3'd2;
  localparam logic [2:0] SECTOR_3 = 3'd3;
  localparam logic [2:0] SECTOR_4 = 3'd4;
  localparam logic [2:0] SECTOR_5 = 3'd5;
  localparam logic [2:0] SECTOR_6 = 3'd6;

  // projection sign patterns {mk >= 0, mj >= 0, mi >= 0}
  localparam logic [2:0] PAT_S6 = 3'd1;
  localparam logic [2:0] PAT_S2 = 3'd2;
  localparam logic [2:0] PAT_S1 = 3'd3;
  localparam logic [2:0] PAT_S4 = 3'd4;
  localparam logic [2:0] PAT_S5 = 3'd5;
  localparam logic [2:0] PAT_S3 = 3'd6;

  typedef struct packed {
    logic [ANG_W-1:0] turn_phase;
    logic signed [VOLT_W-1:0] volt_d;
    logic signed [VOLT_W-1:0] volt_q;
  } cmd_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] sin_v;
    logic signed [TRIG_W-1:0] cos_v;
    logic signed [VOLT_W-1:0] volt_d;
    logic signed [VOLT_W-1:0] volt_q;
  } trig_t;

  typedef struct packed {
    logic signed [AB_W-1:0] v_alpha;
    logic signed [AB_W-1:0] v_beta;
  } ab_t;

  typedef struct packed {
    logic [2:0] sector;
    logic signed [M_W-1:0] t1;
    logic signed [M_W-1:0] t2;
  } times_t;

  // Clamp twice the duty to 0..2^47 and drop the low 16 bits.
  function automatic logic [Q_W-1:0] clamp_q(input logic signed [T_W-1:0] x);
    logic [Q_W-1:0] res;
    if (x < 0) begin
      res = '0;
    end else if (x > TWO_Q46) begin
      res = TWO_Q46[16 +: Q_W];
    end else begin
      res = x[16 +: Q_W];
    end
    return res;
  endfunction

endpackage

// ===== src/ipsvm_trig.sv =====
// Sine/cosine stage: parabolic approximation of one turn, one register stage.
// Depends on ipsvm_pkg.
module ipsvm_trig (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  ipsvm_pkg::cmd_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output ipsvm_pkg::trig_t out_data
);
  import ipsvm_pkg::*;

  logic   v_r;
  logic   en;
  trig_t  data_r, data_nxt;
  logic [ANG_W-1:0] cos_ph;
  logic [14:0] u_s, u_c;
  logic [30:0] prod_s, prod_c;
  logic [15:0] mag_s, mag_c;

  assign en = !v_r || out_ready;
  assign in_ready = en;
  assign out_valid = v_r;
  assign out_data = data_r;

  always_comb begin
    cos_ph = in_data.turn_phase + QUARTER_TURN;
    u_s = in_data.turn_phase[14:0];
    u_c = cos_ph[14:0];
    prod_s = 31'(u_s) * (16'd32768 - 16'(u_s));
    prod_c = 31'(u_c) * (16'd32768 - 16'(u_c));
    mag_s = prod_s[28:13];
    mag_c = prod_c[28:13];
    data_nxt.sin_v = in_data.turn_phase[15] ? -$signed({1'b0, mag_s}) : $signed({1'b0, mag_s});
    data_nxt.cos_v = cos_ph[15] ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});
    data_nxt.volt_d = in_data.volt_d;
    data_nxt.volt_q = in_data.volt_q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ===== src/ipsvm_rot.sv =====
// Inverse Park rotation: products in one stage, alpha/beta sums in the next.
// Depends on ipsvm_pkg.
module ipsvm_rot (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  ipsvm_pkg::trig_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output ipsvm_pkg::ab_t   out_data
);
  import ipsvm_pkg::*;

  logic v1_r, v2_r;
  logic en1, en2;
  logic signed [PROD_W-1:0] pdc_r, pqs_r, pds_r, pqc_r;
  logic signed [PROD_W-1:0] pdc_nxt, pqs_nxt, pds_nxt, pqc_nxt;
  ab_t ab_r, ab_nxt;

  assign en2 = !v2_r || out_ready;
  assign en1 = !v1_r || en2;
  assign in_ready = en1;
  assign out_valid = v2_r;
  assign out_data = ab_r;

  always_comb begin
    pdc_nxt = PROD_W'(in_data.volt_d) * PROD_W'(in_data.cos_v);
    pqs_nxt = PROD_W'(in_data.volt_q) * PROD_W'(in_data.sin_v);
    pds_nxt = PROD_W'(in_data.volt_d) * PROD_W'(in_data.sin_v);
    pqc_nxt = PROD_W'(in_data.volt_q) * PROD_W'(in_data.cos_v);
    ab_nxt.v_alpha = AB_W'(pdc_r) - AB_W'(pqs_r);
    ab_nxt.v_beta = AB_W'(pds_r) + AB_W'(pqc_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      pdc_r <= pdc_nxt;
      pqs_r <= pqs_nxt;
      pds_r <= pds_nxt;
      pqc_r <= pqc_nxt;
    end
    if (en2) begin
      ab_r <= ab_nxt;
    end
  end

endmodule

// ===== src/ipsvm_proj.sv =====
// Sector projections, sector decode and active times T1/T2 over three stages.
// Depends on ipsvm_pkg.
module ipsvm_proj (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ipsvm_pkg::ab_t    in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ipsvm_pkg::times_t out_data
);
  import ipsvm_pkg::*;

  logic v1_r, v2_r, v3_r;
  logic en1, en2, en3;
  logic signed [M_W-1:0] pa_r, pa_nxt;
  logic signed [AB_W-1:0] vb_r;
  logic signed [M_W-1:0] mi_r, mj_r, mk_r;
  logic signed [M_W-1:0] mi_nxt, mj_nxt, mk_nxt;
  logic signed [M_W-1:0] vb_ext;
  logic [2:0] pat;
  times_t tt_r, tt_nxt;

  assign en3 = !v3_r || out_ready;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_ready = en1;
  assign out_valid = v3_r;
  assign out_data = tt_r;

  always_comb begin
    pa_nxt = M_W'(in_data.v_alpha) * M_W'(SQ3_2_Q16);
    vb_ext = M_W'(vb_r);
    mi_nxt = pa_r - (vb_ext <<< 15);
    mj_nxt = vb_ext <<< 16;
    mk_nxt = -pa_r - (vb_ext <<< 15);
  end

  always_comb begin
    pat = {~mk_r[M_W-1], ~mj_r[M_W-1], ~mi_r[M_W-1]};
    tt_nxt.sector = SECTOR_ZERO;
    tt_nxt.t1 = '0;
    tt_nxt.t2 = '0;
    unique case (pat)
      PAT_S6: begin
        tt_nxt.sector = SECTOR_6; tt_nxt.t1 = -mj_r; tt_nxt.t2 = -mk_r;
      end
      PAT_S2: begin
        tt_nxt.sector = SECTOR_2; tt_nxt.t1 = -mk_r; tt_nxt.t2 = -mi_r;
      end
      PAT_S1: begin
        tt_nxt.sector = SECTOR_1; tt_nxt.t1 = mi_r; tt_nxt.t2 = mj_r;
      end
      PAT_S4: begin
        tt_nxt.sector = SECTOR_4; tt_nxt.t1 = -mi_r; tt_nxt.t2 = -mj_r;
      end
      PAT_S5: begin
        tt_nxt.sector = SECTOR_5; tt_nxt.t1 = mk_r; tt_nxt.t2 = mi_r;
      end
      PAT_S3: begin
        tt_nxt.sector = SECTOR_3; tt_nxt.t1 = mj_r; tt_nxt.t2 = mk_r;
      end
      // zero vector, and the impossible all-negative pattern
      default: begin
        tt_nxt.sector = SECTOR_ZERO;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      pa_r <= pa_nxt;
      vb_r <= in_data.v_beta;
    end
    if (en2) begin
      mi_r <= mi_nxt;
      mj_r <= mj_nxt;
      mk_r <= mk_nxt;
    end
    if (en3) begin
      tt_r <= tt_nxt;
    end
  end

endmodule

// ===== src/ipsvm_duty.sv =====
// Phase duty forming: per-sector sums and clamp, then rounded scaling to DUTY_BITS.
// Depends on ipsvm_pkg; the second stage is the block's output register.
module ipsvm_duty #(
  parameter int unsigned DUTY_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ipsvm_pkg::times_t    in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [DUTY_BITS-1:0] duty_a,
  output logic [DUTY_BITS-1:0] duty_b,
  output logic [DUTY_BITS-1:0] duty_c,
  output logic [2:0]           sector
);
  import ipsvm_pkg::*;

  localparam int unsigned S_W = Q_W + DUTY_BITS;
  localparam logic [S_W-1:0] ROUND_HALF = S_W'(64'd1 << 30);
  localparam logic [DUTY_BITS-1:0] FULL = '1;

  logic v1_r, v2_r;
  logic en1, en2;
  logic signed [T_W-1:0] t1e, t2e, pp, mm, pm, mp;
  logic signed [T_W-1:0] da, db, dc;
  logic [Q_W-1:0] qa_r, qb_r, qc_r;
  logic [2:0] sec1_r, sec2_r;
  logic [S_W-1:0] sa, sb, sc;
  logic [DUTY_BITS-1:0] duty_a_r, duty_b_r, duty_c_r;
  logic [DUTY_BITS-1:0] duty_a_nxt, duty_b_nxt, duty_c_nxt;

  assign en2 = !v2_r || out_ready;
  assign en1 = !v1_r || en2;
  assign in_ready = en1;
  assign out_valid = v2_r;
  assign duty_a = duty_a_r;
  assign duty_b = duty_b_r;
  assign duty_c = duty_c_r;
  assign sector = sec2_r;

  always_comb begin
    t1e = T_W'(in_data.t1);
    t2e = T_W'(in_data.t2);
    pp = ONE_Q46 + t1e + t2e;
    mm = ONE_Q46 - t1e - t2e;
    pm = ONE_Q46 + t1e - t2e;
    mp = ONE_Q46 - t1e + t2e;
    da = ONE_Q46;
    db = ONE_Q46;
    dc = ONE_Q46;
    unique case (in_data.sector)
      SECTOR_1: begin da = pp; db = mp; dc = mm; end
      SECTOR_2: begin da = pm; db = pp; dc = mm; end
      SECTOR_3: begin da = mm; db = pp; dc = mp; end
      SECTOR_4: begin da = mm; db = pm; dc = pp; end
      SECTOR_5: begin da = mp; db = mm; dc = pp; end
      SECTOR_6: begin da = pp; db = mm; dc = pm; end
      default: begin da = ONE_Q46; db = ONE_Q46; dc = ONE_Q46; end
    endcase
  end

  // round half up: (q * full + 2^30) >> 31
  always_comb begin
    sa = S_W'(qa_r) * S_W'(FULL) + ROUND_HALF;
    sb = S_W'(qb_r) * S_W'(FULL) + ROUND_HALF;
    sc = S_W'(qc_r) * S_W'(FULL) + ROUND_HALF;
    duty_a_nxt = sa[31 +: DUTY_BITS];
    duty_b_nxt = sb[31 +: DUTY_BITS];
    duty_c_nxt = sc[31 +: DUTY_BITS];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      qa_r <= clamp_q(da);
      qb_r <= clamp_q(db);
      qc_r <= clamp_q(dc);
      sec1_r <= in_data.sector;
    end
    if (en2) begin
      duty_a_r <= duty_a_nxt;
      duty_b_r <= duty_b_nxt;
      duty_c_r <= duty_c_nxt;
      sec2_r <= sec1_r;
    end
  end

endmodule

// ===== src/inverse_park_space_vector_pwm.sv =====
// Top level: inverse Park transform and space vector PWM duty generator.
// Depends on ipsvm_pkg, ipsvm_trig, ipsvm_rot, ipsvm_proj and ipsvm_duty.
//
// Usage:
//   in_*  : one transfer carries an electrical angle (turn fraction) and a
//           d/q voltage command pair in Q1.15.
//   out_* : one transfer per input carries three phase duties
//           (2^DUTY_BITS - 1 is 100 percent) and the sector, 1..6, or 0
//           for the zero vector, in which case all duties sit at 50 percent.
//   Register stages from input transfer to output valid: sine/cosine
//   (1), rotation (2), projections and sector (3), duty forming (2).
//   Throughput is one item per cycle while out_tready stays high; each stage holds its own valid bit.
//   When the receiver stalls, the output register holds its transfer and
//   the stages behind it keep filling until no empty stage is left, then
//   in_tready drops. Results come out in input order.
//   A synchronous reset (rst_n low) empties every stage; no result is
//   pending afterwards. The block has no state between items.
module inverse_park_space_vector_pwm #(
  parameter int unsigned DUTY_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // turn_phase[15:0], volt_d[31:16], volt_q[47:32]
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // duty_a, duty_b, duty_c (DUTY_BITS each), sector (3), zero fill to bytes
  output logic [((3*DUTY_BITS+3+7)/8)*8-1:0] out_tdata
);
  import ipsvm_pkg::*;

  localparam int unsigned PAY_W = 3*DUTY_BITS + 3;

  cmd_t   cmd;
  trig_t  trig;
  ab_t    ab;
  times_t tt;
  logic   trig_v, trig_rdy, ab_v, ab_rdy, tt_v, tt_rdy;
  logic [DUTY_BITS-1:0] duty_a, duty_b, duty_c;
  logic [2:0] sector;

  assign cmd.turn_phase = in_tdata[15:0];
  assign cmd.volt_d = in_tdata[31:16];
  assign cmd.volt_q = in_tdata[47:32];

  ipsvm_trig u_trig (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_ready(in_tready), .in_data(cmd),
    .out_valid(trig_v), .out_ready(trig_rdy), .out_data(trig)
  );

  ipsvm_rot u_rot (
    .clk(clk), .rst_n(rst_n),
    .in_valid(trig_v), .in_ready(trig_rdy), .in_data(trig),
    .out_valid(ab_v), .out_ready(ab_rdy), .out_data(ab)
  );

  ipsvm_proj u_proj (
    .clk(clk), .rst_n(rst_n),
    .in_valid(ab_v), .in_ready(ab_rdy), .in_data(ab),
    .out_valid(tt_v), .out_ready(tt_rdy), .out_data(tt)
  );

  ipsvm_duty #(.DUTY_BITS(DUTY_BITS)) u_duty (
    .clk(clk), .rst_n(rst_n),
    .in_valid(tt_v), .in_ready(tt_rdy), .in_data(tt),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .duty_a(duty_a), .duty_b(duty_b), .duty_c(duty_c), .sector(sector)
  );

  always_comb begin
    out_tdata = '0;
    out_tdata[PAY_W-1:0] = {sector, duty_c, duty_b, duty_a};
  end

endmodule

// ===== src/ipsvm_chk.sv =====
// Port-level checker for the inverse Park / SVPWM block, bound to the top level.
// Depends only on the top level's ports.
module ipsvm_chk #(
  parameter int unsigned DUTY_BITS = 16
) (
  input logic clk,
  input logic rst_n,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready,
  input logic [((3*DUTY_BITS+3+7)/8)*8-1:0] out_tdata
);

  localparam logic [DUTY_BITS-1:0] HALF = DUTY_BITS'(1) << (DUTY_BITS - 1);
  localparam logic [2:0] SEC_ZERO = 3'd0;
  localparam logic [2:0] SEC_BAD = 3'd7;

  logic [2:0] sec;
  assign sec = out_tdata[3*DUTY_BITS +: 3];

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result present after reset");

  a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> sec != SEC_BAD)
    else $error("sector code out of range");

  a_zero_half: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && sec == SEC_ZERO |->
      out_tdata[0 +: DUTY_BITS] == HALF &&
      out_tdata[DUTY_BITS +: DUTY_BITS] == HALF &&
      out_tdata[2*DUTY_BITS +: DUTY_BITS] == HALF)
    else $error("zero vector without half duties");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

endmodule

bind inverse_park_space_vector_pwm ipsvm_chk #(.DUTY_BITS(DUTY_BITS)) u_ipsvm_chk (.*);

// ===== tb/inverse_park_space_vector_pwm_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for inverse_park_space_vector_pwm: directed table, then random items.
// Depends on ipsvm_pkg and the block's RTL; expected duties come from a local predictor.
module inverse_park_space_vector_pwm_tb;
  import ipsvm_pkg::*;

  localparam int unsigned DUTY_BITS = 16;
  localparam int unsigned OUT_W = ((3 * DUTY_BITS + 3 + 7) / 8) * 8;
  localparam int unsigned PIPE_LAT = 8;
  localparam int unsigned N_RANDOM = 1600;
  localparam int unsigned N_QUIET = 150;
  localparam int unsigned LONG_HOLD = 60;
  localparam longint UNIT_Q46 = 64'sd1 <<< 46;
  localparam longint TWICE_FULL = 64'sd1 <<< 47;
  localparam longint SQRT3_HALF = 56756;
  localparam logic [DUTY_BITS-1:0] HALF_DUTY = DUTY_BITS'(1) << (DUTY_BITS - 1);

  typedef struct {
    logic [DUTY_BITS-1:0] duty_a;
    logic [DUTY_BITS-1:0] duty_b;
    logic [DUTY_BITS-1:0] duty_c;
    logic [2:0] sector;
  } pwm_res_t;

  typedef struct {
    logic [15:0] phase;
    logic [15:0] vd;
    logic [15:0] vq;
    bit pinned;
    logic [DUTY_BITS-1:0] ea;
    logic [DUTY_BITS-1:0] eb;
    logic [DUTY_BITS-1:0] ec;
    logic [2:0] esec;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [47:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  pwm_res_t pending_duties[$];
  int unsigned mismatch_count = 0;
  bit hold_output = 1'b0;
  bit quiet_tail = 1'b0;

  // phase, d, q, pinned, duty a/b/c, sector (last four only used when pinned)
  dir_row_t dir_rows[21] = '{
    '{16'h0000, 16'h0000, 16'h0000, 1'b1, HALF_DUTY, HALF_DUTY, HALF_DUTY, SECTOR_ZERO},
    '{16'hFFFF, 16'h0000, 16'h0000, 1'b1, HALF_DUTY, HALF_DUTY, HALF_DUTY, SECTOR_ZERO},
    '{16'h8000, 16'h0000, 16'h0000, 1'b1, HALF_DUTY, HALF_DUTY, HALF_DUTY, SECTOR_ZERO},
    '{16'd2730, 16'd20000, 16'h0000, 1'b0, '0, '0, '0, SECTOR_ZERO},
    '{16'd13653, 16'd20000, 16'h0000, 1'b0, '0, '0, '0, SECTOR_ZERO},
    '{16'd24576, 16'd20000, 16'h0000, 1'b0, '0, '0, '0, SECTOR_ZERO},
    '{16'd35499, 16'd20000, 16'h0000, 1'b0, '0, '0, '0, SECTOR_ZERO},
    '{16'd46422, 16'd20000, 16'h0000, 1'b0, '0, '0, '0, SECTOR_ZERO},
    '{16'd57345, 16'd20000, 16'h0000, 1'b0, '0, '0, '0, SECTOR_ZERO},
    '{16'h0000, 16'h7FFF, 16'h0000, 1'b0, '0, '0, '0, SECTOR_ZERO},
    '{16'h0000, 16'h8000, 16'h0000, 1'b0, '0, '0, '0, SECTOR_ZERO},
    '{16'h4000, 16'h0000, 16'h7FFF, 1'b0, '0, '0, '0, SECTOR_ZERO},
    '{16'hC000, 16'h0000, 16'h8000, 1'b0, '0, '0, '0, SECTOR_ZERO},
    '{16'h2000, 16'h7FFF, 16'h7FFF, 1'b0, '0, '0, '0, SECTOR_ZERO},
    '{16'h6000, 16'h8000, 16'h8000, 1'b0, '0, '0, '0, SECTOR_ZERO},
    '{16'h7FFF, 16'h7FFF, 16'h8000, 1'b0, '0, '0, '0, SECTOR_ZERO},
    '{16'hFFFF, 16'h8000, 16'h7FFF, 1'b0, '0, '0, '0, SECTOR_ZERO},
    '{16'h0000, 16'h0001, 16'h0000, 1'b0, '0, '0, '0, SECTOR_ZERO},
    '{16'h0000, 16'hFFFF, 16'hFFFF, 1'b0, '0, '0, '0, SECTOR_ZERO},
    '{16'hA000, 16'h7FFF, 16'h7FFF, 1'b0, '0, '0, '0, SECTOR_ZERO},
    '{16'h0000, 16'h0000, 16'h0001, 1'b0, '0, '0, '0, SECTOR_ZERO}
  };

  inverse_park_space_vector_pwm #(.DUTY_BITS(DUTY_BITS)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  always #10 clk = ~clk;

  // Parabolic sine over a half turn, Q15 with a peak of exactly 32768.
  function automatic longint parab_sine(input logic [15:0] ph);
    longint u;
    longint mag;
    u = ph[14:0];
    mag = (u * (32768 - u)) >>> 13;
    return ph[15] ? -mag : mag;
  endfunction

  function automatic logic [DUTY_BITS-1:0] duty_scale(input longint twice);
    longint clipped;
    longint q;
    longint full;
    full = (64'sd1 <<< DUTY_BITS) - 1;
    clipped = (twice < 0) ? 64'sd0 : ((twice > TWICE_FULL) ? TWICE_FULL : twice);
    q = clipped >>> 16;
    return DUTY_BITS'((q * full + (64'sd1 <<< 30)) >>> 31);
  endfunction

  function automatic pwm_res_t svpwm_duties(input logic [47:0] word);
    logic [15:0] ph;
    logic [15:0] cph;
    logic [2:0] pat;
    logic [2:0] sec;
    longint vd, vq, sn, cs, va, vb, mi, mj, mk, t1, t2;
    longint pp, mm, pm, mp, da, db, dc;
    pwm_res_t r;
    ph = word[15:0];
    cph = ph + QUARTER_TURN;
    vd = longint'($signed(word[31:16]));
    vq = longint'($signed(word[47:32]));
    sn = parab_sine(ph);
    cs = parab_sine(cph);
    va = vd * cs - vq * sn;
    vb = vd * sn + vq * cs;
    mi = SQRT3_HALF * va - 32768 * vb;
    mj = 65536 * vb;
    mk = -SQRT3_HALF * va - 32768 * vb;
    pat = {mk >= 0, mj >= 0, mi >= 0};
    t1 = 0;
    t2 = 0;
    case (pat)
      PAT_S6: begin sec = SECTOR_6; t1 = -mj; t2 = -mk; end
      PAT_S2: begin sec = SECTOR_2; t1 = -mk; t2 = -mi; end
      PAT_S1: begin sec = SECTOR_1; t1 = mi; t2 = mj; end
      PAT_S4: begin sec = SECTOR_4; t1 = -mi; t2 = -mj; end
      PAT_S5: begin sec = SECTOR_5; t1 = mk; t2 = mi; end
      PAT_S3: begin sec = SECTOR_3; t1 = mj; t2 = mk; end
      default: sec = SECTOR_ZERO;
    endcase
    pp = UNIT_Q46 + t1 + t2;
    mm = UNIT_Q46 - t1 - t2;
    pm = UNIT_Q46 + t1 - t2;
    mp = UNIT_Q46 - t1 + t2;
    da = UNIT_Q46;
    db = UNIT_Q46;
    dc = UNIT_Q46;
    case (sec)
      SECTOR_1: begin da = pp; db = mp; dc = mm; end
      SECTOR_2: begin da = pm; db = pp; dc = mm; end
      SECTOR_3: begin da = mm; db = pp; dc = mp; end
      SECTOR_4: begin da = mm; db = pm; dc = pp; end
      SECTOR_5: begin da = mp; db = mm; dc = pp; end
      SECTOR_6: begin da = pp; db = mm; dc = pm; end
      default: ;
    endcase
    r.duty_a = duty_scale(da);
    r.duty_b = duty_scale(db);
    r.duty_c = duty_scale(dc);
    r.sector = sec;
    return r;
  endfunction

  function automatic logic [15:0] pick_extreme();
    case ($urandom_range(0, 4))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'h0001;
    endcase
  endfunction

  function automatic logic [47:0] rand_command();
    logic [15:0] ph;
    logic [15:0] vd;
    logic [15:0] vq;
    ph = 16'($urandom);
    vd = 16'($urandom);
    vq = 16'($urandom);
    case ($urandom_range(0, 9))
      6: begin
        vd = pick_extreme();
        vq = pick_extreme();
        if ($urandom_range(0, 1)) ph = 16'(16'h4000 * $urandom_range(0, 3) - $urandom_range(0, 1));
      end
      7: begin
        // tiny vectors: zero vector and sign flips right at the sector edges
        vd = 16'($signed($urandom_range(0, 8)) - 4);
        vq = 16'($signed($urandom_range(0, 8)) - 4);
      end
      8: begin
        ph = 16'(10923 * $urandom_range(0, 5) + $urandom_range(0, 6) - 3);
        vq = 16'h0000;
      end
      9: begin
        // near full scale on both axes, drives the duties into the clamp
        vd = 16'($urandom_range(32000, 32767));
        vq = 16'($urandom_range(32000, 32767));
        if ($urandom_range(0, 1)) vd = -vd;
        if ($urandom_range(0, 1)) vq = -vq;
      end
      default: ;
    endcase
    return {vq, vd, ph};
  endfunction

  // Offer one transfer after an optional gap; queue its expected duties once accepted.
  task automatic send_command(input logic [47:0] word, input int unsigned gap,
                              input pwm_res_t want);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= word;
    do @(posedge clk); while (!in_tready);
    pending_duties.push_back(want);
  endtask

  initial begin : stimulus
    logic [47:0] word;
    pwm_res_t want;
    int unsigned gap;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      word = {dir_rows[i].vq, dir_rows[i].vd, dir_rows[i].phase};
      if (dir_rows[i].pinned) begin
        want.duty_a = dir_rows[i].ea;
        want.duty_b = dir_rows[i].eb;
        want.duty_c = dir_rows[i].ec;
        want.sector = dir_rows[i].esec;
      end else begin
        want = svpwm_duties(word);
      end
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
      send_command(word, gap, want);
    end

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM - N_QUIET) quiet_tail = 1'b1;
      // hold the receiver off while items keep coming, so the pipe backs up
      if (i == 400) hold_output = 1'b1;
      // drain completely before carrying on
      if (i == 800 || i == 1200) begin
        in_tvalid <= 1'b0;
        while (pending_duties.size() != 0) @(posedge clk);
      end
      word = rand_command();
      gap = 0;
      if (!quiet_tail && !(i >= 400 && i < 450) && (i % 256) < 192 && $urandom_range(0, 4) == 0)
        gap = $urandom_range(1, 5);
      send_command(word, gap, svpwm_duties(word));
    end
    in_tvalid <= 1'b0;

    while (pending_duties.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : receiver
    int unsigned cyc;
    cyc = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      cyc++;
      if (hold_output) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_output = 1'b0;
        out_tready <= 1'b1;
      end else if (!quiet_tail && (cyc % 512) < 384 && $urandom_range(0, 6) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    pwm_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_duties.size() == 0) begin
        $error("result transfer with nothing expected: %h", out_tdata);
        mismatch_count++;
      end else begin
        want = pending_duties.pop_front();
        if (out_tdata[0 +: DUTY_BITS] !== want.duty_a) begin
          $error("duty_a: expected %0d, got %0d", want.duty_a, out_tdata[0 +: DUTY_BITS]);
          mismatch_count++;
        end
        if (out_tdata[DUTY_BITS +: DUTY_BITS] !== want.duty_b) begin
          $error("duty_b: expected %0d, got %0d", want.duty_b,
                 out_tdata[DUTY_BITS +: DUTY_BITS]);
          mismatch_count++;
        end
        if (out_tdata[2 * DUTY_BITS +: DUTY_BITS] !== want.duty_c) begin
          $error("duty_c: expected %0d, got %0d", want.duty_c,
                 out_tdata[2 * DUTY_BITS +: DUTY_BITS]);
          mismatch_count++;
        end
        if (out_tdata[3 * DUTY_BITS +: 3] !== want.sector) begin
          $error("sector: expected %0d, got %0d", want.sector, out_tdata[3 * DUTY_BITS +: 3]);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/ipsvm_pkg.sv
src/ipsvm_trig.sv
src/ipsvm_rot.sv
src/ipsvm_proj.sv
src/ipsvm_duty.sv
src/inverse_park_space_vector_pwm.sv
src/ipsvm_chk.sv
tb/inverse_park_space_vector_pwm_tb.sv
